/* rtl/wmfc_pkg.sv */
// Shared types and constants of the WLAN management frame classifier.
package wmfc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 4096;
  localparam int unsigned SSID_MAX_BYTES  = 32;
  localparam int unsigned POS_W           = 16;
  localparam int unsigned ELEM_W          = POS_W + 1;
  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned SSID_W          = SSID_MAX_BYTES * 8;
  localparam int unsigned SLEN_W          = 6;
  localparam int unsigned SIDX_W          = 5;

  localparam logic [POS_W-1:0]  MAX_POS       = POS_W'(MAX_FRAME_BYTES);
  localparam logic [ELEM_W-1:0] IE_FIRST      = ELEM_W'(36);
  localparam logic [POS_W-1:0]  DEAUTH_FIRST  = POS_W'(10);
  localparam logic [POS_W-1:0]  DEAUTH_END    = POS_W'(16);
  localparam logic [POS_W-1:0]  BEACON_FIRST  = POS_W'(16);
  localparam logic [POS_W-1:0]  BEACON_END    = POS_W'(22);
  localparam logic [POS_W-1:0]  MIN_LEN       = POS_W'(4);
  localparam logic [POS_W-1:0]  DEAUTH_MIN    = POS_W'(16);
  localparam logic [POS_W-1:0]  BEACON_MIN    = POS_W'(36);
  localparam logic [7:0]        SSID_ID       = 8'h00;
  localparam logic [7:0]        SSID_LEN_MAX  = 8'(SSID_MAX_BYTES);

  localparam logic [3:0] SUBTYPE_DEAUTH   = 4'hC;
  localparam logic [3:0] SUBTYPE_DISASSOC = 4'hA;
  localparam logic [3:0] SUBTYPE_BEACON   = 4'h8;
  localparam logic [1:0] TYPE_MGMT        = 2'h0;

  typedef enum logic [1:0] {
    KIND_IGNORED  = 2'd0,
    KIND_DEAUTH   = 2'd1,
    KIND_DISASSOC = 2'd2,
    KIND_BEACON   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SLEN_W-1:0] ssid_length;
    logic [SSID_W-1:0] ssid;
    logic [ADDR_W-1:0] station_address;
    kind_t             frame_kind;
  } result_t;

endpackage

/* rtl/wmfc_frame_track.sv */
// Per-frame state: byte position, header capture, element walk and classification.
module wmfc_frame_track (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [7:0]               frame_byte,
  input  logic                     last_byte,
  input  logic                     management_frame,
  output logic                     result_valid,
  output wmfc_pkg::result_t        result
);

  logic [wmfc_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]                  control_byte, control_byte_next;
  logic                        mgmt_seen, mgmt_seen_next;
  logic [wmfc_pkg::ADDR_W-1:0] deauth_address, deauth_address_next;
  logic [wmfc_pkg::ADDR_W-1:0] beacon_address, beacon_address_next;
  logic [wmfc_pkg::ELEM_W-1:0] element_start, element_start_next;
  logic [7:0]                  element_id, element_id_next;
  logic [wmfc_pkg::SLEN_W-1:0] element_length, element_length_next;
  logic [wmfc_pkg::ELEM_W-1:0] ssid_end, ssid_end_next;
  logic [wmfc_pkg::SLEN_W-1:0] ssid_count, ssid_count_next;
  logic [wmfc_pkg::SSID_W-1:0] ssid_store, ssid_store_next;
  logic                        ssid_found, ssid_found_next;

  logic [wmfc_pkg::ELEM_W-1:0] pos_ext;
  logic [2:0]                  addr_idx;
  logic [3:0]                  subtype;
  logic [1:0]                  ftype;
  logic                        ssid_ok;

  always_comb begin
    byte_position_next  = byte_position;
    control_byte_next   = control_byte;
    mgmt_seen_next      = mgmt_seen & management_frame;
    deauth_address_next = deauth_address;
    beacon_address_next = beacon_address;
    element_start_next  = element_start;
    element_id_next     = element_id;
    element_length_next = element_length;
    ssid_end_next       = ssid_end;
    ssid_count_next     = ssid_count;
    ssid_store_next     = ssid_store;
    ssid_found_next     = ssid_found;
    pos_ext             = {1'b0, byte_position};
    addr_idx            = 3'd0;

    // Bytes past the length bound leave the frame state untouched, but for the management flag.
    if (byte_position < wmfc_pkg::MAX_POS) begin
      byte_position_next = byte_position + 1'b1;
      if (byte_position == '0) begin
        control_byte_next = frame_byte;
      end
      if (byte_position >= wmfc_pkg::DEAUTH_FIRST && byte_position < wmfc_pkg::DEAUTH_END) begin
        addr_idx = 3'(byte_position - wmfc_pkg::DEAUTH_FIRST);
        deauth_address_next[addr_idx*8 +: 8] = frame_byte;
      end
      if (byte_position >= wmfc_pkg::BEACON_FIRST && byte_position < wmfc_pkg::BEACON_END) begin
        addr_idx = 3'(byte_position - wmfc_pkg::BEACON_FIRST);
        beacon_address_next[addr_idx*8 +: 8] = frame_byte;
      end

      if (!ssid_found) begin
        if (pos_ext == element_start) begin
          element_id_next = frame_byte;
        end else if (pos_ext == element_start + 1'b1) begin
          if (element_id == wmfc_pkg::SSID_ID && frame_byte != 8'd0 &&
              frame_byte <= wmfc_pkg::SSID_LEN_MAX) begin
            ssid_found_next     = 1'b1;
            element_length_next = wmfc_pkg::SLEN_W'(frame_byte);
            ssid_count_next     = '0;
            ssid_end_next       = pos_ext + wmfc_pkg::ELEM_W'(1) +
                                  wmfc_pkg::ELEM_W'(frame_byte);
          end else begin
            element_start_next = element_start + wmfc_pkg::ELEM_W'(2) +
                                 wmfc_pkg::ELEM_W'(frame_byte);
          end
        end
      end else if (ssid_count < element_length) begin
        // The SSID body starts on the byte right after the length byte.
        ssid_store_next[ssid_count[wmfc_pkg::SIDX_W-1:0]*8 +: 8] = frame_byte;
        ssid_count_next = ssid_count + 1'b1;
      end
    end

    subtype = control_byte_next[7:4];
    ftype   = control_byte_next[3:2];
    ssid_ok = 1'b0;

    result.frame_kind      = wmfc_pkg::KIND_IGNORED;
    result.station_address = '0;
    result.ssid            = '0;
    result.ssid_length     = '0;
    if (mgmt_seen_next && byte_position_next >= wmfc_pkg::MIN_LEN &&
        ftype == wmfc_pkg::TYPE_MGMT) begin
      if ((subtype == wmfc_pkg::SUBTYPE_DEAUTH || subtype == wmfc_pkg::SUBTYPE_DISASSOC) &&
          byte_position_next >= wmfc_pkg::DEAUTH_MIN) begin
        result.frame_kind = (subtype == wmfc_pkg::SUBTYPE_DEAUTH) ?
                            wmfc_pkg::KIND_DEAUTH : wmfc_pkg::KIND_DISASSOC;
        result.station_address = deauth_address_next;
      end else if (subtype == wmfc_pkg::SUBTYPE_BEACON &&
                   byte_position_next >= wmfc_pkg::BEACON_MIN) begin
        result.frame_kind      = wmfc_pkg::KIND_BEACON;
        result.station_address = beacon_address_next;
        ssid_ok = ssid_found_next && (ssid_end_next <= {1'b0, byte_position_next});
      end
    end
    if (ssid_ok) begin
      result.ssid        = ssid_store_next;
      result.ssid_length = element_length_next;
    end
    result_valid = take && last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      byte_position  <= '0;
      control_byte   <= '0;
      mgmt_seen      <= 1'b1;
      deauth_address <= '0;
      beacon_address <= '0;
      element_start  <= wmfc_pkg::IE_FIRST;
      element_id     <= '0;
      element_length <= '0;
      ssid_end       <= '0;
      ssid_count     <= '0;
      ssid_store     <= '0;
      ssid_found     <= 1'b0;
    end else if (take) begin
      byte_position  <= byte_position_next;
      control_byte   <= control_byte_next;
      mgmt_seen      <= mgmt_seen_next;
      deauth_address <= deauth_address_next;
      beacon_address <= beacon_address_next;
      element_start  <= element_start_next;
      element_id     <= element_id_next;
      element_length <= element_length_next;
      ssid_end       <= ssid_end_next;
      ssid_count     <= ssid_count_next;
      ssid_store     <= ssid_store_next;
      ssid_found     <= ssid_found_next;
    end
  end

endmodule

/* rtl/wmfc_out_reg.sv */
// Result holding register between the classifier and the output stream.
module wmfc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  wmfc_pkg::result_t  in_result,
  output logic               can_take,
  output logic               out_valid,
  input  logic               out_ready,
  output wmfc_pkg::result_t  out_result
);

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= in_valid;
    end
    if (can_take && in_valid) begin
      out_result <= in_result;
    end
  end

endmodule

/* rtl/wlan_mgmt_frame_classifier.sv */
// Top level of the WLAN management frame classifier.
//
//   channel   direction  tdata                            tuser             tlast
//   s_axis    in         frame_byte[7:0]                  management_frame  last_byte
//   m_axis    out        address, ssid words, length      frame_kind        -
//
// One byte is taken per cycle while s_axis_tready is high; a result appears in the cycle after its last byte is taken.
// The only storage between the two sides is the result register, which holds one result.
// While that result waits with m_axis_tready low, s_axis_tready is low for every byte.
// The register drains and refills in the same cycle, so frames stream back to back.
// Reset is synchronous; after it the block waits for byte 0 of a new frame.
module wlan_mgmt_frame_classifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // frame_byte
  input  logic         s_axis_tlast,
  input  logic         s_axis_tuser,   // management_frame
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // station_address[47:0], ssid_word0[111:48], ssid_word1[175:112], ssid_word2[239:176],
  // ssid_word3[303:240], ssid_length[309:304], zero padding[311:310]
  output logic [311:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // frame_kind
);

  logic              take;
  logic              res_valid;
  wmfc_pkg::result_t res;
  wmfc_pkg::result_t res_q;

  assign take = s_axis_tvalid && s_axis_tready;

  wmfc_frame_track u_track (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .frame_byte       (s_axis_tdata),
    .last_byte        (s_axis_tlast),
    .management_frame (s_axis_tuser),
    .result_valid     (res_valid),
    .result           (res)
  );

  wmfc_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (res_valid),
    .in_result  (res),
    .can_take   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (res_q)
  );

  assign m_axis_tdata = {2'b00, res_q.ssid_length, res_q.ssid, res_q.station_address};
  assign m_axis_tuser = res_q.frame_kind;

endmodule
